@@ design/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvc_pkg: shared constants and types of the LRU key/value cache
// Sizes, the capacity register reset and the controller/datapath command word.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 16;
  localparam int READ_W     = VALUE_BITS + 1;
  localparam int CAP_W      = 5;
  localparam int RANK_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_SET = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_LOOK  = 3'b010,
    ST_APPLY = 3'b100
  } lkvc_state_t;

  typedef struct packed {
    logic latch;  // capture the input word
    logic look;   // compare keys, pick victim
    logic apply;  // update storage, load result
  } lkvc_cmd_t;

endpackage

`default_nettype wire

@@ design/lkvc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lkvc_ctrl: sequencing controller
// Walks each accepted word through lookup and apply, drives busy and strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  output lkvc_cmd_t cmd,
  output logic      out_valid
);

  lkvc_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply     = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_strobe_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_APPLY))
    else $error("result strobe without apply step");
  a_latch_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> state_r == ST_LOOK)
    else $error("accepted word did not enter lookup");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.latch, cmd.look, cmd.apply}))
    else $error("more than one command at once");
`endif

endmodule

`default_nettype wire

@@ design/lkvc_dp.sv @@
// ----------------------------------------------------------------------------
// lkvc_dp: cache datapath
// Entry storage, parallel key compare, LRU rank update and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_dp
  import lkvc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire lkvc_cmd_t               cmd,
  input  wire logic                    in_mode,
  input  wire logic [KEY_BITS-1:0]     in_key,
  input  wire logic [VALUE_BITS-1:0]   in_write_value,
  input  wire logic                    cfg_we,
  input  wire logic [CAP_W-1:0]        cfg_capacity,
  output logic                         out_found,
  output logic signed [READ_W-1:0]     out_read_value,
  output logic                         out_evicted
);

  logic                  mode_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] wval_r;

  logic [KEY_BITS-1:0]   keys_r [ENTRIES];
  logic [VALUE_BITS-1:0] vals_r [ENTRIES];
  logic [RANK_W-1:0]     rank_r [ENTRIES];
  logic [ENTRIES-1:0]    valid_r;
  logic [CNT_W-1:0]      count_r;
  logic [CAP_W-1:0]      capacity_r;

  logic [ENTRIES-1:0]    hit_oh_r, hit_oh_nxt;
  logic [ENTRIES-1:0]    victim_oh_r, victim_oh_nxt;
  logic                  ev_r, ev_nxt;
  logic [RANK_W-1:0]     hit_rank_r, hit_rank_nxt;
  logic [VALUE_BITS-1:0] hit_val_r, hit_val_nxt;

  logic                  found_r;
  logic signed [READ_W-1:0] rd_r;
  logic                  evicted_r;

  logic [CMP_W-1:0]      cap_ext, eff_cap;
  logic [RANK_W-1:0]     oldest_rank;
  logic [ENTRIES-1:0]    kept, free_vec, ins_oh;

  // Valid ranks form 0..count-1, so the oldest entry holds rank count-1.
  assign oldest_rank = RANK_W'(count_r - CNT_W'(1));

  always_comb begin
    cap_ext = CMP_W'(capacity_r);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  always_comb begin
    hit_rank_nxt = '0;
    hit_val_nxt  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_oh_nxt[i]    = valid_r[i] && (keys_r[i] == key_r);
      victim_oh_nxt[i] = valid_r[i] && (rank_r[i] == oldest_rank);
      hit_rank_nxt     = hit_rank_nxt | (hit_oh_nxt[i] ? rank_r[i] : '0);
      hit_val_nxt      = hit_val_nxt | (hit_oh_nxt[i] ? vals_r[i] : '0);
    end
    ev_nxt = (mode_r == MODE_SET) && !(|hit_oh_nxt) &&
             (CMP_W'(count_r) >= eff_cap) && (count_r != '0);
  end

  // Free slots after eviction; take the lowest one.
  assign kept     = valid_r & ~(ev_r ? victim_oh_r : '0);
  assign free_vec = ~kept;
  assign ins_oh   = free_vec & (~free_vec + ENTRIES'(1));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_mode;
      key_r  <= in_key;
      wval_r <= in_write_value;
    end
    if (cmd.look) begin
      hit_oh_r    <= hit_oh_nxt;
      victim_oh_r <= victim_oh_nxt;
      ev_r        <= ev_nxt;
      hit_rank_r  <= hit_rank_nxt;
      hit_val_r   <= hit_val_nxt;
    end
    if (cmd.apply) begin
      found_r   <= |hit_oh_r;
      rd_r      <= ((mode_r == MODE_GET) && (|hit_oh_r)) ?
                   $signed({1'b0, hit_val_r}) : '1;
      evicted_r <= ev_r;
    end
    if (cmd.apply && (mode_r == MODE_SET)) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (|hit_oh_r) begin
          if (hit_oh_r[i]) begin
            vals_r[i] <= wval_r;
          end
        end else if (ins_oh[i]) begin
          keys_r[i] <= key_r;
          vals_r[i] <= wval_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      count_r    <= '0;
      capacity_r <= CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_capacity;
      end
      if (cmd.apply && (mode_r == MODE_SET)) begin
        if (|hit_oh_r) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (hit_oh_r[i]) begin
              rank_r[i] <= '0;
            end else if (valid_r[i] && (rank_r[i] < hit_rank_r)) begin
              rank_r[i] <= rank_r[i] + RANK_W'(1);
            end
          end
        end else begin
          // age the survivors, drop the victim, place the new word
          for (int i = 0; i < ENTRIES; i++) begin
            if (ins_oh[i]) begin
              rank_r[i] <= '0;
            end else if (kept[i]) begin
              rank_r[i] <= rank_r[i] + RANK_W'(1);
            end else begin
              rank_r[i] <= '0;
            end
          end
          valid_r <= kept | ins_oh;
          count_r <= ev_r ? count_r : count_r + CNT_W'(1);
        end
      end
    end
  end

  assign out_found      = found_r;
  assign out_read_value = rd_r;
  assign out_evicted    = evicted_r;

`ifndef ASSERT_OFF
  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_oh_nxt))
    else $error("key present in more than one entry");
  a_victim_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(victim_oh_nxt))
    else $error("more than one oldest entry");
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("entry count out of step with valid marks");
  a_victim_found: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.look && ev_nxt) |-> (victim_oh_nxt != '0))
    else $error("eviction with no oldest entry");
`endif

endmodule

`default_nettype wire

@@ design/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache with LRU replacement
//
//   channel  ports                                   handshake
//   input    in_mode, in_key, in_write_value         start && !busy
//   result   out_found, out_read_value, out_evicted  out_valid, one cycle
//   config   cfg_capacity                            cfg_valid && cfg_ready
//
// A word passes capture, parallel key compare and apply; busy is high while
// the word is in compare and apply. The result strobe comes the cycle after
// apply, the same cycle in which the next word may be accepted.
// The receiver cannot stall. Synchronous reset clears all valid marks and
// ranks and loads capacity 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache
  import lkvc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_mode,
  input  wire logic [KEY_BITS-1:0]   in_key,
  input  wire logic [VALUE_BITS-1:0] in_write_value,
  output logic                       out_valid,
  output logic                       out_found,
  output logic signed [READ_W-1:0]   out_read_value,
  output logic                       out_evicted,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CAP_W-1:0]      cfg_capacity
);

  lkvc_cmd_t cmd;

  assign cfg_ready = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  lkvc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_mode        (in_mode),
    .in_key         (in_key),
    .in_write_value (in_write_value),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_capacity   (cfg_capacity),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted)
  );

endmodule

`default_nettype wire

@@ dv/tb_lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache: self-checking bench for the LRU key/value cache
// Drives get and set words through the start/busy port and tracks the
// expected table contents, recency order and capacity in a scoreboard.
// Every strobed result is compared field by field in arrival order. Capacity
// is rewritten between phases, including zero, the maximum and a value below
// the current fill.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lru_key_value_cache
  import lkvc_pkg::*;
();

  typedef struct packed {
    logic                     found;
    logic signed [READ_W-1:0] read_value;
    logic                     evicted;
  } lookup_result_t;

  class cache_tracker;
    logic [KEY_BITS-1:0]   keys   [ENTRIES];
    logic [VALUE_BITS-1:0] values [ENTRIES];
    bit                    live   [ENTRIES];
    int unsigned           rank   [ENTRIES];
    int unsigned           fill;
    logic [CAP_W-1:0]      capacity;
    lookup_result_t        pending_results[$];
    int unsigned           errors;

    function new();
      foreach (live[i]) begin
        live[i] = 1'b0;
        rank[i] = 0;
      end
      fill     = 0;
      capacity = CAP_RESET;
      errors   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      capacity = c;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void report(string what, lookup_result_t exp_r, lookup_result_t got_r);
      errors++;
      if (errors <= 10)
        $display({"mismatch (%s): expected found=%0b read=%0d evicted=%0b, ",
                  "got found=%0b read=%0d evicted=%0b"},
                 what, exp_r.found, $signed(exp_r.read_value), exp_r.evicted,
                 got_r.found, $signed(got_r.read_value), got_r.evicted);
    endfunction

    // Predict the result of one accepted word and advance the table.
    function void note_word(logic mode, logic [KEY_BITS-1:0] key,
                            logic [VALUE_BITS-1:0] wval);
      lookup_result_t exp_r;
      int             hit;
      int             victim;
      int unsigned    limit;
      int unsigned    r;
      hit = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (hit < 0 && live[i] && keys[i] == key) hit = i;
      exp_r.found      = (hit >= 0);
      exp_r.read_value = '1;
      exp_r.evicted    = 1'b0;
      if (mode == MODE_GET) begin
        if (hit >= 0) exp_r.read_value = {1'b0, values[hit]};
      end else if (hit >= 0) begin
        r = rank[hit];
        for (int i = 0; i < ENTRIES; i++)
          if (live[i] && rank[i] < r) rank[i]++;
        rank[hit]   = 0;
        values[hit] = wval;
      end else begin
        // zero capacity acts as one, oversize as full depth
        if (capacity == 0) limit = 1;
        else if (capacity > ENTRIES) limit = ENTRIES;
        else limit = capacity;
        if (fill >= limit || fill >= ENTRIES) begin
          victim = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (live[i] && (victim < 0 || rank[i] > rank[victim])) victim = i;
          if (victim >= 0) begin
            live[victim] = 1'b0;
            rank[victim] = 0;
            if (fill > 0) fill--;
            exp_r.evicted = 1'b1;
          end
        end
        for (int i = 0; i < ENTRIES; i++)
          if (live[i]) rank[i]++;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!live[i]) begin
            live[i]   = 1'b1;
            keys[i]   = key;
            values[i] = wval;
            rank[i]   = 0;
            fill++;
            break;
          end
        end
      end
      pending_results.push_back(exp_r);
    endfunction

    function void check_result(lookup_result_t got_r);
      lookup_result_t exp_r;
      if (pending_results.size() == 0) begin
        exp_r = '0;
        report("no word outstanding", exp_r, got_r);
        return;
      end
      exp_r = pending_results.pop_front();
      if (got_r.found !== exp_r.found) report("found", exp_r, got_r);
      else if (got_r.read_value !== exp_r.read_value) report("read_value", exp_r, got_r);
      else if (got_r.evicted !== exp_r.evicted) report("evicted", exp_r, got_r);
    endfunction
  endclass

  localparam int IDLE_LIMIT = 500;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_mode;
  logic [KEY_BITS-1:0]      in_key;
  logic [VALUE_BITS-1:0]    in_write_value;
  logic                     out_valid;
  logic                     out_found;
  logic signed [READ_W-1:0] out_read_value;
  logic                     out_evicted;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CAP_W-1:0]         cfg_capacity;

  cache_tracker tracker;
  int unsigned  quiet_cycles;

  lru_key_value_cache dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_key         (in_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_capacity   (cfg_capacity)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compare every strobed result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      tracker.check_result('{out_found, out_read_value, out_evicted});
  end

  // Abort when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Start stays high across back-to-back words; drop it only for a gap.
  task automatic send_word(logic mode, logic [KEY_BITS-1:0] key,
                           logic [VALUE_BITS-1:0] wval);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_mode        <= mode;
    in_key         <= key;
    in_write_value <= wval;
    do @(posedge clk); while (busy);
    tracker.note_word(mode, key, wval);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] c);
    cfg_valid    <= 1'b1;
    cfg_capacity <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_capacity(c);
  endtask

  // Mostly reuse a small key pool so gets hit and sets update or evict.
  task automatic random_phase(logic [CAP_W-1:0] c, int count);
    logic [KEY_BITS-1:0] pool [24];
    int                  pool_size;
    logic [KEY_BITS-1:0] key;
    write_capacity(c);
    pool_size = $urandom_range(1, 24);
    foreach (pool[i]) pool[i] = KEY_BITS'($urandom);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 7) == 0) key = KEY_BITS'($urandom);
      else key = pool[$urandom_range(0, pool_size - 1)];
      send_word($urandom_range(0, 1) ? MODE_SET : MODE_GET, key,
                VALUE_BITS'($urandom));
    end
    drain();
  endtask

  initial begin
    tracker        = new();
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_mode        <= MODE_GET;
    in_key         <= '0;
    in_write_value <= '0;
    cfg_valid      <= 1'b0;
    cfg_capacity   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, hits, a miss and an update at full capacity
    write_capacity(5'd16);
    send_word(MODE_SET, 16'h0000, 16'h0000);
    send_word(MODE_SET, 16'hffff, 16'hffff);
    send_word(MODE_GET, 16'h0000, 16'hffff);
    send_word(MODE_GET, 16'hffff, 16'h0000);
    send_word(MODE_GET, 16'h1234, 16'h5678);
    send_word(MODE_SET, 16'h0000, 16'habcd);
    send_word(MODE_GET, 16'h0000, 16'h0000);
    send_word(MODE_SET, 16'h0001, 16'h1111);
    send_word(MODE_SET, 16'h0002, 16'h2222);
    send_word(MODE_SET, 16'h0003, 16'h3333);
    drain();

    // capacity lowered below the fill: each insert evicts one
    write_capacity(5'd2);
    send_word(MODE_SET, 16'h0004, 16'h4444);
    send_word(MODE_GET, 16'hffff, 16'h0000);
    send_word(MODE_SET, 16'h0005, 16'h5555);
    send_word(MODE_SET, 16'h0002, 16'h2020);
    send_word(MODE_GET, 16'h0002, 16'h0000);
    send_word(MODE_GET, 16'h0000, 16'h0000);
    drain();

    // zero capacity behaves as one
    write_capacity(5'd0);
    send_word(MODE_SET, 16'h0006, 16'h6666);
    send_word(MODE_GET, 16'h0006, 16'h0000);
    send_word(MODE_SET, 16'h0007, 16'h7777);
    drain();

    random_phase(5'd31, 58);
    random_phase(5'd1, 58);
    random_phase(5'd16, 58);
    random_phase(5'd7, 58);
    random_phase(5'd0, 58);
    random_phase(5'd20, 58);
    random_phase(5'd3, 58);
    random_phase(5'd12, 58);
    random_phase(5'd2, 58);
    random_phase(5'd9, 58);

    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
